>>> rtl/core/tdith_pkg.sv
`timescale 1ns / 1ps

package tdith_pkg;

  // Generator and output range
  localparam logic [31:0] SEED_RESET = 32'hDEAD_BEEF;
  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;
  localparam int unsigned DROP_BITS_DEF = 8;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W = 16;
  // Wide sum: sample plus one byte minus one byte never leaves 34 bits
  localparam int unsigned SUM_W = SAMPLE_W + 2;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_MODE = 1'b0,
    CFG_SEED = 1'b1
  } cfg_reg_e;

  // Mode register codes
  typedef enum logic [0:0] {
    MODE_DITHER = 1'b0,
    MODE_PASS   = 1'b1
  } mode_e;

  // Two noise bytes for one item
  typedef struct packed {
    logic [7:0] add_byte;
    logic [7:0] sub_byte;
  } noise_t;

  // One xorshift32 step
  function automatic logic [31:0] prng_advance(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

endpackage

>>> rtl/core/tdith_prng.sv
`timescale 1ns / 1ps

module tdith_prng (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 seed_we_i,
  input  logic [31:0]          seed_i,
  output tdith_pkg::noise_t    noise_o
);
  import tdith_pkg::*;

  logic [31:0] state_q, state_d;
  logic [31:0] step1, step2;

  // Two chained steps from the current word
  always_comb begin
    step1 = prng_advance(state_q);
    step2 = prng_advance(step1);
    noise_o.add_byte = step1[7:0];
    noise_o.sub_byte = step2[7:0];
  end

  // Seed load (zero maps to one) or advance by two
  always_comb begin
    state_d = state_q;
    if (seed_we_i) begin
      state_d = (seed_i == 32'd0) ? 32'd1 : seed_i;
    end else if (adv_i) begin
      state_d = step2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Zero is a fixed point and must never be reached
  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q != 32'd0)
    else $error("prng word is zero");

  // Word moves only on an advance or a seed write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv_i && !seed_we_i) |=> $stable(state_q))
    else $error("prng word changed without cause");

  // A seed write loads the seed, or one for a zero seed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_we_i |=> (state_q == (($past(seed_i) == 32'd0) ? 32'd1 : $past(seed_i))))
    else $error("seed not loaded");

endmodule

>>> rtl/core/tdith_requant.sv
`timescale 1ns / 1ps

module tdith_requant #(
  parameter int unsigned DROP_BITS = tdith_pkg::DROP_BITS_DEF
) (
  input  logic signed [tdith_pkg::SAMPLE_W-1:0] sample_i,
  input  tdith_pkg::noise_t                     noise_i,
  input  logic                                  pass_i,
  output logic signed [tdith_pkg::OUT_W-1:0]    sample_o,
  output logic                                  clip_o
);
  import tdith_pkg::*;

  logic signed [SUM_W-1:0] wide_sample;
  logic signed [SUM_W-1:0] dith_sum;
  logic signed [SUM_W-1:0] shifted;
  logic signed [SUM_W-1:0] value;
  logic signed [SUM_W-1:0] lim_max, lim_min;

  // Wide add of one noise byte and subtract of the other, floor shift, then mode select
  always_comb begin
    wide_sample = SUM_W'(sample_i);
    dith_sum = wide_sample + $signed({{(SUM_W-8){1'b0}}, noise_i.add_byte})
                           - $signed({{(SUM_W-8){1'b0}}, noise_i.sub_byte});
    shifted = dith_sum >>> DROP_BITS;
    value = pass_i ? wide_sample : shifted;
  end

  // Saturate to the 16-bit range
  always_comb begin
    lim_max = SUM_W'(OUT_MAX);
    lim_min = SUM_W'(OUT_MIN);
    clip_o = 1'b0;
    sample_o = value[OUT_W-1:0];
    if (value > lim_max) begin
      sample_o = OUT_MAX;
      clip_o = 1'b1;
    end else if (value < lim_min) begin
      sample_o = OUT_MIN;
      clip_o = 1'b1;
    end
  end

endmodule

>>> rtl/core/tpdf_dither_24_to_16.sv
`timescale 1ns / 1ps
// Latency: two register stages; an accepted item passes through the input register,
// then the result register, which drives the output stream.
// Throughput: one item per cycle; the input stalls only when both registers
// hold an item and m_axis_tready is low.
// Reset: pipeline empty, mode = dither, generator word = 0xDEADBEEF.

module tpdf_dither_24_to_16 #(
  parameter int unsigned DROP_BITS = tdith_pkg::DROP_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
  input  logic        s_axis_tlast,   // end_of_buffer
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  output logic        m_axis_tuser,   // [0] clipped
  output logic        m_axis_tlast    // end_flag
);
  import tdith_pkg::*;

  mode_e mode_q;
  logic  in_fire, s1_adv, seed_we;

  // Input register
  logic                       s1_valid_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic                       s1_last_q;
  logic                       s1_pass_q;
  noise_t                     s1_noise_q;
  noise_t                     noise;

  // Result register
  logic                       out_valid_q;
  logic signed [OUT_W-1:0]    out_sample_q;
  logic                       out_clip_q;
  logic                       out_last_q;
  logic signed [OUT_W-1:0]    rq_sample;
  logic                       rq_clip;

  // Handshake
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign seed_we       = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_SEED);

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_DITHER;
    end else if (cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_MODE)) begin
      mode_q <= mode_e'(cfg_wdata_i[0]);
    end
  end

  // Generator advances by two steps for each item taken in dither mode
  tdith_prng u_prng (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (in_fire && (mode_q == MODE_DITHER)),
    .seed_we_i (seed_we),
    .seed_i    (cfg_wdata_i),
    .noise_o   (noise)
  );

  // Input register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Input register: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q <= $signed(s_axis_tdata);
      s1_last_q   <= s_axis_tlast;
      s1_pass_q   <= (mode_q == MODE_PASS);
      s1_noise_q  <= noise;
    end
  end

  tdith_requant #(
    .DROP_BITS (DROP_BITS)
  ) u_requant (
    .sample_i (s1_sample_q),
    .noise_i  (s1_noise_q),
    .pass_i   (s1_pass_q),
    .sample_o (rq_sample),
    .clip_o   (rq_clip)
  );

  // Result register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_sample_q <= rq_sample;
      out_clip_q   <= rq_clip;
      out_last_q   <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_clip_q;
  assign m_axis_tlast  = out_last_q;

  // Back-pressure only when both registers hold an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // A clipped result sits at one of the range limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |-> (out_sample_q == OUT_MAX || out_sample_q == OUT_MIN))
    else $error("clipped result not at a limit");

  // An accepted item reaches the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item lost");

endmodule

>>> test/tpdf_dither_24_to_16_test.sv
`timescale 1ns / 1ps

module tpdf_dither_24_to_16_test;
  import tdith_pkg::*;

  localparam int unsigned DROP = DROP_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SEG_ITEMS = 56;
  localparam int unsigned MAX_SHOWN = 10;

  // One result item: sample, clip flag, end flag
  typedef struct packed {
    logic [OUT_W-1:0] smp;
    logic             clip;
    logic             eob;
  } res_t;

  // Directed row: either a register write or one item (with an optional fixed answer)
  typedef struct packed {
    logic             is_cfg;
    cfg_reg_e         idx;
    logic [31:0]      wdata;
    logic [31:0]      smp;
    logic             eob;
    logic             fixed;
    logic [OUT_W-1:0] out;
    logic             clip;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
    // dither mode after reset
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'h8000_0000, 1'b1, 1'b1, 16'h8000, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'h007F_FFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'hFF80_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    // zero seed turns into one
    '{1'b1, CFG_SEED, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0001_2345, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_SEED, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_0100, 1'b0, 1'b0, 16'h0000, 1'b0},
    // passthrough, written with junk in the upper bits
    '{1'b1, CFG_MODE, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_7FFF, 1'b0, 1'b1, 16'h7FFF, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_8000, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'hFFFF_8000, 1'b0, 1'b1, 16'h8000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'hFFFF_7FFF, 1'b1, 1'b1, 16'h8000, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_0000, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'h8000_0000, 1'b0, 1'b1, 16'h8000, 1'b1},
    '{1'b0, CFG_MODE, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0},
    // back to dither; generator word carries over
    '{1'b1, CFG_MODE, 32'hFFFF_FFFE, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0040_0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'hFFC0_0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{1'b1, CFG_SEED, 32'hDEAD_BEEF, 32'h0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{1'b0, CFG_MODE, 32'h0, 32'h0000_0000, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  // DUT ports
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_idx_i = CFG_MODE;
  logic [31:0]      cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  // Fixed answer travelling alongside the item on the input side
  logic             row_fixed = 1'b0;
  res_t             row_answer = '0;

  // Predictor state
  mode_e            pred_mode = MODE_DITHER;
  logic [31:0]      noise_word = SEED_RESET;
  res_t             pending_q[$];

  // Idling control and bookkeeping
  int unsigned      src_idle = 0;
  int unsigned      snk_stall = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      err_cnt = 0;
  int unsigned      item_cnt = 0;
  int unsigned      result_cnt = 0;
  int unsigned      clip_cnt = 0;
  int unsigned      cfg_cnt = 0;

  tpdf_dither_24_to_16 i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Watchdog
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // One xorshift32 step
  function automatic logic [31:0] xorshift_step(logic [31:0] x);
    x = x ^ (x << XS_A);
    x = x ^ (x >> XS_B);
    x = x ^ (x << XS_C);
    return x;
  endfunction

  // Expected output for one item; advances the noise word in dither mode
  function automatic res_t requantize(logic [31:0] smp, logic eob);
    logic [31:0]      w1;
    logic [31:0]      w2;
    logic signed [SUM_W-1:0] wide;
    res_t             r;
    wide = {{(SUM_W-32){smp[31]}}, smp};
    if (pred_mode == MODE_DITHER) begin
      w1 = xorshift_step(noise_word);
      w2 = xorshift_step(w1);
      noise_word = w2;
      wide = wide + $signed({{(SUM_W-8){1'b0}}, w1[7:0]})
                  - $signed({{(SUM_W-8){1'b0}}, w2[7:0]});
      wide = wide >>> DROP;
    end
    r.eob = eob;
    r.clip = 1'b0;
    if (wide > 34'sd32767) begin
      r.smp = OUT_MAX;
      r.clip = 1'b1;
    end else if (wide < -34'sd32768) begin
      r.smp = OUT_MIN;
      r.clip = 1'b1;
    end else begin
      r.smp = wide[OUT_W-1:0];
    end
    return r;
  endfunction

  // Sink side: random backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall);
  end

  // Monitor: register writes, accepted items, result check
  always @(posedge clk_i) begin
    res_t pred;
    res_t want;
    res_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_cnt++;
        case (cfg_reg_e'(cfg_idx_i))
          CFG_MODE: pred_mode = mode_e'(cfg_wdata_i[0]);
          CFG_SEED: noise_word = (cfg_wdata_i != 32'h0) ? cfg_wdata_i : 32'h1;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        item_cnt++;
        pred = requantize(s_axis_tdata, s_axis_tlast);
        if (row_fixed) pending_q.push_back(row_answer);
        else pending_q.push_back(pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt++;
        got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
        if (got.clip) clip_cnt++;
        if (pending_q.size() == 0) begin
          if (err_cnt < MAX_SHOWN)
            $display("unexpected result: out=%0d clip=%0b last=%0b",
                     $signed(got.smp), got.clip, got.eob);
          err_cnt++;
        end else begin
          want = pending_q.pop_front();
          if (got != want) begin
            if (err_cnt < MAX_SHOWN)
              $display({"mismatch at result %0d: expected out=%0d clip=%0b last=%0b,",
                        " got out=%0d clip=%0b last=%0b"},
                       result_cnt, $signed(want.smp), want.clip, want.eob,
                       $signed(got.smp), got.clip, got.eob);
            err_cnt++;
          end
        end
      end
    end
  end

  // Offer one item, with random idle cycles in front of it
  task automatic send_item(input logic [31:0] smp, input logic eob,
                           input logic fixed, input res_t answer);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= eob;
    row_fixed     <= fixed;
    row_answer    <= answer;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every outstanding result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_q.size() != 0);
  endtask

  // Register write, only with the pipeline empty
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [31:0] smp;
    logic [31:0] seed;
    logic        pass_seg;
    int          base;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, no idling
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TBL[r].is_cfg) begin
        write_reg(DIR_TBL[r].idx, DIR_TBL[r].wdata);
      end else begin
        send_item(DIR_TBL[r].smp, DIR_TBL[r].eob, DIR_TBL[r].fixed,
                  '{DIR_TBL[r].out, DIR_TBL[r].clip, DIR_TBL[r].eob});
      end
    end

    // random segments: idling pattern changes every two segments
    for (int seg = 0; seg < 8; seg++) begin
      case (seg / 2)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 81; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 81; end
        default: begin src_idle = 17; snk_stall = 17; end
      endcase
      pass_seg = (seg == 2 || seg == 5);
      case (seg)
        0: seed = 32'h0000_0000;
        1: seed = 32'hFFFF_FFFF;
        7: seed = SEED_RESET;
        default: seed = $urandom();
      endcase
      write_reg(CFG_SEED, seed);
      write_reg(CFG_MODE, {31'($urandom_range(32'h7FFF_FFFF)), pass_seg});
      for (int n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: smp = {{8{1'b0}}, 24'($urandom())};
          5, 6: smp = {{16{1'b0}}, 16'($urandom())};
          7: begin
            // around the 24-bit clamp edges
            base = ($urandom_range(1)) ? 32'sd8388352 : -32'sd8388608;
            smp = base + $urandom_range(511) - 256;
          end
          8: begin
            // around the 16-bit clamp edges
            base = ($urandom_range(1)) ? 32'sd32767 : -32'sd32768;
            smp = base + $urandom_range(7) - 3;
          end
          default: smp = $urandom();
        endcase
        // sign-extend the nominal-width picks
        if (smp[31:24] == 8'h00 && smp[23] && $urandom_range(1)) smp[31:24] = 8'hFF;
        if (smp[31:16] == 16'h0000 && smp[15] && $urandom_range(1)) smp[31:16] = 16'hFFFF;
        send_item(smp, ($urandom_range(7) == 0), 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (pending_q.size() != 0) err_cnt++;

    $display("covered %0d items and %0d results (%0d clipped) over %0d register writes,",
             item_cnt, result_cnt, clip_cnt, cfg_cnt);
    $display("both modes, zero and all-ones seeds, four idle/backpressure mixes; %0d errors",
             err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tdith_pkg.sv
rtl/core/tdith_prng.sv
rtl/core/tdith_requant.sv
rtl/core/tpdf_dither_24_to_16.sv
test/tpdf_dither_24_to_16_test.sv
